/* sv/adc_boxcar_smoother_watchdog_core_macros.svh */
// Assertion macros shared by the boxcar smoother and watchdog RTL.
`ifndef ADC_BOXCAR_SMOOTHER_WATCHDOG_CORE_MACROS_SVH
`define ADC_BOXCAR_SMOOTHER_WATCHDOG_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on clk_i while out of reset.
`define BXW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a property on clk_i, reset included.
`define BXW_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BXW_ASSERT(lbl, prop, msg)
`define BXW_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* sv/bxw_pkg.sv */
// Types, constants and helpers for the ADC boxcar smoother and watchdog.
`default_nettype none
package bxw_pkg;

  // Sizing
  localparam int SmoothDepth = 16;
  localparam int FastDepth   = 4;
  localparam int NumChannels = 4;
  localparam int SampleBits  = 12;

  localparam int InChannels  = 4;
  localparam int FieldBits   = 12;
  localparam int OutBits     = 12;
  localparam int WideBits    = 32;

  // Floor of log2, evaluated at elaboration only
  function automatic int floor_log2(input int v);
    int s;
    int x;
    s = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      s = s + 1;
    end
    return s;
  endfunction

  localparam int SmoothShift = floor_log2(SmoothDepth);
  localparam int FastShift   = floor_log2(FastDepth);
  localparam int SmoothSumW  = SampleBits + $clog2(SmoothDepth);
  localparam int FastSumW    = SampleBits + $clog2(FastDepth);

  typedef logic [SampleBits-1:0] sample_t;
  typedef logic [OutBits-1:0]    avg_t;

  // Register map
  localparam int RegIdxW = 3;
  localparam int AddrW   = RegIdxW + 2;
  localparam logic [RegIdxW-1:0] RegChannelMask   = 3'd0;
  localparam logic [RegIdxW-1:0] RegFastEnable    = 3'd1;
  localparam logic [RegIdxW-1:0] RegFastChannel   = 3'd2;
  localparam logic [RegIdxW-1:0] RegTickDivide    = 3'd3;
  localparam logic [RegIdxW-1:0] RegWatchdogEn    = 3'd4;
  localparam logic [RegIdxW-1:0] RegWdLimit       = 3'd5;

  // Register reset values
  localparam logic [3:0]  RstChannelMask = 4'd15;
  localparam logic        RstFastEnable  = 1'b0;
  localparam logic [1:0]  RstFastChannel = 2'd0;
  localparam logic [7:0]  RstTickDivide  = 8'd5;
  localparam logic        RstWatchdogEn  = 1'b1;
  localparam logic [15:0] RstWdLimit     = 16'd500;

  typedef struct packed {
    logic [3:0]  channel_mask;
    logic        fast_enable;
    logic [1:0]  fast_channel;
    logic [7:0]  tick_divide;
    logic        watchdog_enable;
    logic [15:0] wd_limit;
  } cfg_t;

  typedef struct packed {
    logic [11:0] sample_ch0;
    logic [11:0] sample_ch1;
    logic [11:0] sample_ch2;
    logic [11:0] sample_ch3;
    logic        wd_toggle_bit;
  } in_t;

  typedef struct packed {
    logic [11:0] avg_ch0;
    logic [11:0] avg_ch1;
    logic [11:0] avg_ch2;
    logic [11:0] avg_ch3;
    logic [11:0] avg_fast;
    logic        control_tick;
    logic        wd_expired;
  } out_t;

  // Tick and watchdog status toward the top level
  typedef struct packed {
    logic tick;
    logic expired_d;
    logic expired_q;
  } wd_status_t;

  // Keep the low SampleBits of a raw input field
  function automatic sample_t to_sample(input logic [FieldBits-1:0] raw);
    logic [WideBits-1:0] w;
    w = WideBits'(raw);
    return w[SampleBits-1:0];
  endfunction

endpackage
`default_nettype wire

/* sv/bxw_cell.sv */
// One ring cell: holds a sample and takes its neighbor's value on advance.
`default_nettype none
module bxw_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            shift_i,
  input  wire bxw_pkg::sample_t d_i,
  output bxw_pkg::sample_t     q_o
);

  bxw_pkg::sample_t val_q;

  // Load the neighbor's sample on advance, clear at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else if (shift_i) begin
      val_q <= d_i;
    end
  end

  assign q_o = val_q;

endmodule
`default_nettype wire

/* sv/bxw_lane.sv */
// Channel smoothing ring: a rotating chain of cells plus its running sum.
`default_nettype none
module bxw_lane (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire logic             wr_i,
  input  wire bxw_pkg::sample_t sample_i,
  output bxw_pkg::avg_t         avg_o
);

  bxw_pkg::sample_t cell_q [bxw_pkg::SmoothDepth];
  bxw_pkg::sample_t head;
  bxw_pkg::sample_t fresh;
  logic [bxw_pkg::SmoothSumW-1:0] sum_q, sum_d;
  logic [bxw_pkg::WideBits-1:0]   avg_w;

  // The head cell is the slot at the current ring position
  assign head  = cell_q[0];
  assign fresh = wr_i ? sample_i : head;

  // Rotate the chain: each cell takes its neighbor, the tail takes the new slot value
  for (genvar i = 0; i < bxw_pkg::SmoothDepth; i++) begin : g_cell
    if (i == bxw_pkg::SmoothDepth - 1) begin : g_tail
      bxw_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(adv_i),
        .d_i    (fresh),
        .q_o    (cell_q[i])
      );
    end else begin : g_body
      bxw_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(adv_i),
        .d_i    (cell_q[i+1]),
        .q_o    (cell_q[i])
      );
    end
  end

  // Swap the oldest sample for the new one in the running sum
  always_comb begin
    sum_d = sum_q;
    if (adv_i && wr_i) begin
      sum_d = sum_q - bxw_pkg::SmoothSumW'(head) + bxw_pkg::SmoothSumW'(sample_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  // Average after this frame's write
  assign avg_w = bxw_pkg::WideBits'(sum_d >> bxw_pkg::SmoothShift);
  assign avg_o = avg_w[bxw_pkg::OutBits-1:0];

endmodule
`default_nettype wire

/* sv/bxw_fast_lane.sv */
// Fast smoothing ring: a short rotating chain of cells plus its running sum.
`default_nettype none
module bxw_fast_lane (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire logic             wr_i,
  input  wire bxw_pkg::sample_t sample_i,
  output bxw_pkg::avg_t         avg_o
);

  bxw_pkg::sample_t cell_q [bxw_pkg::FastDepth];
  bxw_pkg::sample_t head;
  bxw_pkg::sample_t fresh;
  logic [bxw_pkg::FastSumW-1:0] sum_q, sum_d;
  logic [bxw_pkg::WideBits-1:0] avg_w;

  assign head  = cell_q[0];
  assign fresh = wr_i ? sample_i : head;

  // Rotate the chain on every accepted frame
  for (genvar i = 0; i < bxw_pkg::FastDepth; i++) begin : g_cell
    if (i == bxw_pkg::FastDepth - 1) begin : g_tail
      bxw_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(adv_i),
        .d_i    (fresh),
        .q_o    (cell_q[i])
      );
    end else begin : g_body
      bxw_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(adv_i),
        .d_i    (cell_q[i+1]),
        .q_o    (cell_q[i])
      );
    end
  end

  // Swap the oldest sample for the new one in the running sum
  always_comb begin
    sum_d = sum_q;
    if (adv_i && wr_i) begin
      sum_d = sum_q - bxw_pkg::FastSumW'(head) + bxw_pkg::FastSumW'(sample_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign avg_w = bxw_pkg::WideBits'(sum_d >> bxw_pkg::FastShift);
  assign avg_o = avg_w[bxw_pkg::OutBits-1:0];

endmodule
`default_nettype wire

/* sv/bxw_tick_wd.sv */
// Frame divider for the control tick and the saturating host watchdog.
`default_nettype none
module bxw_tick_wd (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire logic          toggle_i,
  input  wire bxw_pkg::cfg_t cfg_i,
  output bxw_pkg::wd_status_t st_o
);

  logic [7:0]  frame_q, frame_d, frame_inc;
  logic [15:0] cnt_q, cnt_d, cnt_inc;
  logic        last_q, last_d;
  logic        exp_q, exp_d;
  logic        tick;

  // Fire the tick once the count reaches the divide, or on wrap
  assign frame_inc = frame_q + 8'd1;
  assign tick      = (frame_inc >= cfg_i.tick_divide) || (frame_inc == 8'd0);

  // Saturate instead of wrapping
  assign cnt_inc = (cnt_q != 16'hFFFF) ? (cnt_q + 16'd1) : cnt_q;

  always_comb begin
    frame_d = frame_q;
    cnt_d   = cnt_q;
    last_d  = last_q;
    exp_d   = exp_q;
    if (adv_i) begin
      frame_d = tick ? 8'd0 : frame_inc;
      if (tick) begin
        last_d = toggle_i;
        if (cfg_i.watchdog_enable) begin
          cnt_d = cnt_inc;
          if (toggle_i != last_q) begin
            cnt_d = '0;
            exp_d = 1'b0;
          end else if (cnt_inc > cfg_i.wd_limit) begin
            exp_d = 1'b1;
          end
        end else begin
          cnt_d = '0;
          exp_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      cnt_q   <= '0;
      last_q  <= 1'b0;
      exp_q   <= 1'b0;
    end else begin
      frame_q <= frame_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      exp_q   <= exp_d;
    end
  end

  assign st_o.tick      = tick;
  assign st_o.expired_d = exp_d;
  assign st_o.expired_q = exp_q;

endmodule
`default_nettype wire

/* sv/adc_boxcar_smoother_watchdog_core.sv */
// Output: the result of an accepted frame is registered and shows in the cycle after it is taken.
// Throughput: one frame per cycle unless the output stalls; each ring is a chain of cells that
// rotates one step per frame, and the running sums take one subtract and one add per frame.
// Reset: asynchronous, clears every ring cell, sum, counter and the watchdog at
// once and loads the register defaults; no clearing pass follows.
`default_nettype none
`include "adc_boxcar_smoother_watchdog_core_macros.svh"
module adc_boxcar_smoother_watchdog_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // frame input
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire bxw_pkg::in_t                in_data_i,
  // result output
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output bxw_pkg::out_t                    out_data_o,
  // register port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bxw_pkg::AddrW-1:0]   paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  bxw_pkg::cfg_t       cfg_q;
  bxw_pkg::wd_status_t wd_st;
  bxw_pkg::sample_t    samples [bxw_pkg::InChannels];
  bxw_pkg::avg_t       avg     [bxw_pkg::InChannels];
  bxw_pkg::avg_t       avg_fast;
  bxw_pkg::out_t       out_q, out_d;
  logic                out_valid_q;
  logic                accept;
  logic                fast_wr;
  logic [bxw_pkg::RegIdxW-1:0] reg_idx;
  logic                cfg_write;

  // Register port
  assign pready    = 1'b1;
  assign reg_idx   = paddr[bxw_pkg::AddrW-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_mask    <= bxw_pkg::RstChannelMask;
      cfg_q.fast_enable     <= bxw_pkg::RstFastEnable;
      cfg_q.fast_channel    <= bxw_pkg::RstFastChannel;
      cfg_q.tick_divide     <= bxw_pkg::RstTickDivide;
      cfg_q.watchdog_enable <= bxw_pkg::RstWatchdogEn;
      cfg_q.wd_limit        <= bxw_pkg::RstWdLimit;
    end else if (cfg_write) begin
      unique case (reg_idx)
        bxw_pkg::RegChannelMask: cfg_q.channel_mask    <= pwdata[3:0];
        bxw_pkg::RegFastEnable:  cfg_q.fast_enable     <= pwdata[0];
        bxw_pkg::RegFastChannel: cfg_q.fast_channel    <= pwdata[1:0];
        bxw_pkg::RegTickDivide:  cfg_q.tick_divide     <= pwdata[7:0];
        bxw_pkg::RegWatchdogEn:  cfg_q.watchdog_enable <= pwdata[0];
        bxw_pkg::RegWdLimit:     cfg_q.wd_limit        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_idx)
      bxw_pkg::RegChannelMask: prdata = 32'(cfg_q.channel_mask);
      bxw_pkg::RegFastEnable:  prdata = 32'(cfg_q.fast_enable);
      bxw_pkg::RegFastChannel: prdata = 32'(cfg_q.fast_channel);
      bxw_pkg::RegTickDivide:  prdata = 32'(cfg_q.tick_divide);
      bxw_pkg::RegWatchdogEn:  prdata = 32'(cfg_q.watchdog_enable);
      bxw_pkg::RegWdLimit:     prdata = 32'(cfg_q.wd_limit);
      default:                 prdata = '0;
    endcase
  end

  // Take a frame whenever the output register is free or being emptied
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign samples[0] = bxw_pkg::to_sample(in_data_i.sample_ch0);
  assign samples[1] = bxw_pkg::to_sample(in_data_i.sample_ch1);
  assign samples[2] = bxw_pkg::to_sample(in_data_i.sample_ch2);
  assign samples[3] = bxw_pkg::to_sample(in_data_i.sample_ch3);

  // One smoothing ring per present channel; absent channels read as zero
  for (genvar c = 0; c < bxw_pkg::InChannels; c++) begin : g_lane
    if (c < bxw_pkg::NumChannels) begin : g_on
      bxw_lane u_lane (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .adv_i   (accept),
        .wr_i    (cfg_q.channel_mask[c]),
        .sample_i(samples[c]),
        .avg_o   (avg[c])
      );
    end else begin : g_off
      assign avg[c] = '0;
    end
  end

  // Fast ring follows the selected channel when that channel exists
  assign fast_wr = cfg_q.fast_enable &&
                   (32'(cfg_q.fast_channel) < 32'(bxw_pkg::NumChannels));

  bxw_fast_lane u_fast (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (accept),
    .wr_i    (fast_wr),
    .sample_i(samples[cfg_q.fast_channel]),
    .avg_o   (avg_fast)
  );

  bxw_tick_wd u_tick_wd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (accept),
    .toggle_i(in_data_i.wd_toggle_bit),
    .cfg_i   (cfg_q),
    .st_o    (wd_st)
  );

  // Assemble the result of the frame being accepted
  always_comb begin
    out_d.avg_ch0      = avg[0];
    out_d.avg_ch1      = avg[1];
    out_d.avg_ch2      = avg[2];
    out_d.avg_ch3      = avg[3];
    out_d.avg_fast     = avg_fast;
    out_d.control_tick = wd_st.tick;
    out_d.wd_expired   = wd_st.expired_d;
  end

  // Output register: load on accept, drop valid once the result transfers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `BXW_ASSERT(a_accept_gives_result, accept |=> out_valid_o, "accepted frame produced no result")
  `BXW_ASSERT(a_expire_needs_tick, (accept && !wd_st.expired_q) |=> (!out_data_o.wd_expired || out_data_o.control_tick), "watchdog expired on a frame without a tick")
  `BXW_ASSERT_RST(a_reset_no_result, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule
`default_nettype wire
